### src/fta_pkg.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator package
// Widths, codes, reset values and the control types of the shared divider.
// ----------------------------------------------------------------------------
package fta_pkg;

	localparam int ELAPSED_W = 48;
	localparam int STEP_W    = 32;
	localparam int BUDGET_W  = 16;
	localparam int LOST_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int TOTAL_W   = 64;
	localparam int CNT_W     = 6;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0] WHOLE_ITERS = 6'd48;
	localparam logic [CNT_W-1:0] FRAC_ITERS  = 6'd16;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	localparam logic REG_STEP_LENGTH = 1'b0;
	localparam logic REG_STEP_BUDGET = 1'b1;

	localparam logic [STEP_W-1:0]   STEP_LENGTH_RST = 32'd16666666;
	localparam logic [BUDGET_W-1:0] STEP_BUDGET_RST = 16'd5;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] iters;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

### src/fta_ifs.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator channels
// Valid/ready interfaces for the command word and the result word.
// ----------------------------------------------------------------------------
interface fta_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic signed [fta_pkg::ELAPSED_W-1:0] elapsed;

	modport source (output valid, cmd, elapsed, input ready);
	modport sink (input valid, cmd, elapsed, output ready);
endinterface

interface fta_res_if;
	logic                          valid;
	logic                          ready;
	logic [fta_pkg::BUDGET_W-1:0]  run_steps;
	logic [fta_pkg::LOST_W-1:0]    lost_steps;
	logic [fta_pkg::FRAC_W-1:0]    blend_fraction;
	logic [fta_pkg::TOTAL_W-1:0]   steps_total;

	modport source (output valid, run_steps, lost_steps, blend_fraction, steps_total,
		input ready);
	modport sink (input valid, run_steps, lost_steps, blend_fraction, steps_total,
		output ready);
endinterface

### src/fta_div.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fta_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fta_pkg::div_ctl_t                  ctl,
	input  logic [fta_pkg::STEP_W-1:0]         init_rem,
	input  logic [fta_pkg::ELAPSED_W-1:0]      dividend,
	input  logic [fta_pkg::STEP_W-1:0]         divisor,
	output fta_pkg::div_sts_t                  sts,
	output logic [fta_pkg::ELAPSED_W-1:0]      quotient,
	output logic [fta_pkg::STEP_W-1:0]         remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [fta_pkg::CNT_W-1:0]       cnt_q;
	logic [fta_pkg::STEP_W-1:0]      rem_q;
	logic [fta_pkg::ELAPSED_W-1:0]   dvd_q;
	logic [fta_pkg::STEP_W+1:0]      diff;
	logic [fta_pkg::STEP_W-1:0]      rem_next;
	logic                            bit_in;

	assign bit_in   = dvd_q[fta_pkg::ELAPSED_W-1];
	assign diff     = {1'b0, rem_q, bit_in} - {2'b00, divisor};
	assign rem_next = diff[fta_pkg::STEP_W+1] ? {rem_q[fta_pkg::STEP_W-2:0], bit_in}
		: diff[fta_pkg::STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == fta_pkg::CNT_W'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - fta_pkg::CNT_W'(1);
				if (cnt_q == fta_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= init_rem;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[fta_pkg::ELAPSED_W-2:0], ~diff[fta_pkg::STEP_W+1]};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

### src/fixed_timestep_accumulator.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator
// Adds elapsed time to a remainder, splits it into whole fixed steps and
// reports run steps, lost steps, a Q0.16 blend fraction and a running total.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     word
//  item      in         valid/ready   cmd, elapsed
//  result    out        valid/ready   run_steps, lost_steps, blend_fraction, steps_total
//  apb       in         psel/penable  step_length, step_budget
//
// An advance passes through the shared bit-serial divider twice, first for the whole steps
// and then for the fraction, with sequencing states before, between and after. A clear
// skips the divider and goes straight to the result. One word is in work at a time;
// item.ready is low until its result is loaded into the output register. A stalled
// result holds. Reset clears the remainder, the total and the registers to their
// defaults.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fta_pkg::ADDR_W-1:0]      paddr,
	input  logic [fta_pkg::DATA_W-1:0]      pwdata,
	output logic [fta_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	fta_cmd_if.sink                         item,
	fta_res_if.source                       result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WHOLE,
		ST_FSTART,
		ST_FRAC,
		ST_FIN
	} state_t;

	state_t                            state_q;
	logic [fta_pkg::STEP_W-1:0]        step_length_q;
	logic [fta_pkg::BUDGET_W-1:0]      step_budget_q;
	logic [fta_pkg::STEP_W-1:0]        rem_q;
	logic [fta_pkg::TOTAL_W-1:0]       total_q;
	logic [fta_pkg::BUDGET_W-1:0]      run_q;
	logic [fta_pkg::LOST_W-1:0]        lost_q;
	logic [fta_pkg::FRAC_W-1:0]        frac_q;
	logic                              out_valid_q;
	logic [fta_pkg::BUDGET_W-1:0]      out_run_q;
	logic [fta_pkg::LOST_W-1:0]        out_lost_q;
	logic [fta_pkg::FRAC_W-1:0]        out_frac_q;
	logic [fta_pkg::TOTAL_W-1:0]       out_total_q;
	logic                              div_start_q;
	logic [fta_pkg::CNT_W-1:0]         div_iters_q;
	logic [fta_pkg::STEP_W-1:0]        div_init_q;
	logic [fta_pkg::ELAPSED_W-1:0]     div_dvd_q;

	fta_pkg::div_ctl_t                 div_ctl;
	fta_pkg::div_sts_t                 div_sts;
	logic [fta_pkg::ELAPSED_W-1:0]     div_quo;
	logic [fta_pkg::STEP_W-1:0]        div_rem;

	logic                              cfg_wr;
	logic [fta_pkg::STEP_W-1:0]        step_eff;
	logic [fta_pkg::BUDGET_W-1:0]      budget_eff;
	logic                              el_pos;
	logic [fta_pkg::ELAPSED_W-1:0]     sum;
	logic                              whole_lt;
	logic [fta_pkg::BUDGET_W-1:0]      run_next;
	logic [fta_pkg::ELAPSED_W-1:0]     lost_wide;
	logic [fta_pkg::LOST_W-1:0]        lost_next;
	logic                              out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_length_q <= fta_pkg::STEP_LENGTH_RST;
			step_budget_q <= fta_pkg::STEP_BUDGET_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fta_pkg::REG_STEP_LENGTH: step_length_q <= pwdata;
				fta_pkg::REG_STEP_BUDGET: step_budget_q <= pwdata[fta_pkg::BUDGET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fta_pkg::REG_STEP_LENGTH: prdata = step_length_q;
			fta_pkg::REG_STEP_BUDGET: prdata = {{(fta_pkg::DATA_W-fta_pkg::BUDGET_W){1'b0}},
				step_budget_q};
			default: prdata = '0;
		endcase
	end

	assign step_eff   = (step_length_q == '0) ? fta_pkg::STEP_W'(1) : step_length_q;
	assign budget_eff = (step_budget_q == '0) ? fta_pkg::BUDGET_W'(1) : step_budget_q;

	assign el_pos = !item.elapsed[fta_pkg::ELAPSED_W-1] && (item.elapsed != '0);
	assign sum    = {{(fta_pkg::ELAPSED_W-fta_pkg::STEP_W){1'b0}}, rem_q}
		+ (el_pos ? fta_pkg::ELAPSED_W'(item.elapsed) : fta_pkg::ELAPSED_W'(0));

	assign whole_lt  = div_quo < {{(fta_pkg::ELAPSED_W-fta_pkg::BUDGET_W){1'b0}}, budget_eff};
	assign run_next  = whole_lt ? div_quo[fta_pkg::BUDGET_W-1:0] : budget_eff;
	assign lost_wide = div_quo - {{(fta_pkg::ELAPSED_W-fta_pkg::BUDGET_W){1'b0}}, run_next};
	assign lost_next = (|lost_wide[fta_pkg::ELAPSED_W-1:fta_pkg::LOST_W]) ? '1
		: lost_wide[fta_pkg::LOST_W-1:0];

	assign out_free = !out_valid_q || result.ready;

	assign div_ctl.start = div_start_q;
	assign div_ctl.iters = div_iters_q;

	fta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.init_rem (div_init_q),
		.dividend (div_dvd_q),
		.divisor  (step_eff),
		.sts      (div_sts),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= ((state_q == ST_IDLE) && item.valid
				&& (item.cmd == fta_pkg::CMD_ADVANCE)) || (state_q == ST_FSTART);
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						if (item.cmd == fta_pkg::CMD_CLEAR) begin
							rem_q   <= '0;
							total_q <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_WHOLE;
						end
					end
				end
				ST_WHOLE: begin
					if (div_sts.done) begin
						rem_q   <= div_rem;
						state_q <= ST_FSTART;
					end
				end
				ST_FSTART: begin
					total_q <= total_q + {{(fta_pkg::TOTAL_W-fta_pkg::BUDGET_W){1'b0}}, run_q};
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					if (div_sts.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				run_q       <= '0;
				lost_q      <= '0;
				frac_q      <= '0;
				div_iters_q <= fta_pkg::WHOLE_ITERS;
				div_init_q  <= '0;
				div_dvd_q   <= sum;
			end
			ST_WHOLE: begin
				if (div_sts.done) begin
					run_q       <= run_next;
					lost_q      <= lost_next;
					div_iters_q <= fta_pkg::FRAC_ITERS;
					div_init_q  <= div_rem;
					div_dvd_q   <= '0;
				end
			end
			ST_FRAC: begin
				if (div_sts.done) begin
					frac_q <= div_quo[fta_pkg::FRAC_W-1:0];
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_run_q   <= run_q;
					out_lost_q  <= lost_q;
					out_frac_q  <= frac_q;
					out_total_q <= total_q;
				end
			end
			default: ;
		endcase
	end

	assign item.ready            = (state_q == ST_IDLE);
	assign result.valid          = out_valid_q;
	assign result.run_steps      = out_run_q;
	assign result.lost_steps     = out_lost_q;
	assign result.blend_fraction = out_frac_q;
	assign result.steps_total    = out_total_q;

endmodule

### src/fta_checker.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator checker
// Port-level properties of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module fta_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pready,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [fta_pkg::BUDGET_W-1:0]    run_steps,
	input logic [fta_pkg::LOST_W-1:0]      lost_steps,
	input logic [fta_pkg::FRAC_W-1:0]      blend_fraction,
	input logic [fta_pkg::TOTAL_W-1:0]     steps_total
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_steps)
			&& $stable(lost_steps) && $stable(blend_fraction) && $stable(steps_total))
		else $error("Stalled result word changed or dropped.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("A new word was taken while one was in work.");

	a_lost_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lost_steps == '0) || (run_steps != '0))
		else $error("Steps were dropped while the budget was not used.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("Configuration port stalled.");

endmodule

bind fixed_timestep_accumulator fta_checker u_fta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.run_steps     (result.run_steps),
	.lost_steps    (result.lost_steps),
	.blend_fraction(result.blend_fraction),
	.steps_total   (result.steps_total)
);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Fixed timestep accumulator testbench
// Drives advance and clear words through the item channel under several step
// length and budget settings, predicts every result word with an internal
// model of the remainder and the step total, and checks each result word field
// by field with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import fta_pkg::*;

	typedef struct packed {
		logic                        cmd;
		logic signed [ELAPSED_W-1:0] elapsed;
	} tick_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] run;
		logic [LOST_W-1:0]   lost;
		logic [FRAC_W-1:0]   frac;
		logic [TOTAL_W-1:0]  total;
	} step_report_t;

	localparam logic signed [ELAPSED_W-1:0] ELAPSED_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ELAPSED_W-1:0] ELAPSED_MIN = 48'sh8000_0000_0000;
	localparam logic [63:0] LOST_SAT = 64'h0000_0000_FFFF_FFFF;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fta_cmd_if cmd_ch ();
	fta_res_if res_ch ();

	fixed_timestep_accumulator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (cmd_ch),
		.result  (res_ch)
	);

	logic [STEP_W-1:0]   cfg_step_len = STEP_LENGTH_RST;
	logic [BUDGET_W-1:0] cfg_budget = STEP_BUDGET_RST;
	logic [STEP_W-1:0]   carry_ns = '0;
	logic [TOTAL_W-1:0]  total_steps = '0;

	tick_t        tick_q[$];
	step_report_t due_reports[$];
	int unsigned  ticks_queued = 0;
	int unsigned  ticks_taken = 0;
	int unsigned  mismatches = 0;
	int unsigned  send_gap = 0;
	int unsigned  recv_hold = 0;
	bit           send_calm = 1'b0;
	bit           recv_calm = 1'b0;
	tick_t        next_tick;
	step_report_t got_report;
	step_report_t want_report;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Advances the step model by one accepted word and queues the result it causes.
	function automatic void account_tick(input logic op, input logic [ELAPSED_W-1:0] el);
		logic [63:0]  step;
		logic [63:0]  budget;
		logic [63:0]  sum;
		logic [63:0]  whole;
		logic [63:0]  run;
		logic [63:0]  lost;
		step_report_t r;
		r = '0;
		if (op == CMD_CLEAR) begin
			carry_ns = '0;
			total_steps = '0;
		end else begin
			step = (cfg_step_len == '0) ? 64'd1 : {32'd0, cfg_step_len};
			budget = (cfg_budget == '0) ? 64'd1 : {48'd0, cfg_budget};
			sum = {32'd0, carry_ns};
			if (!el[ELAPSED_W-1] && el != '0) begin
				sum += {16'd0, el};
			end
			whole = sum / step;
			carry_ns = STEP_W'(sum % step);
			run = (whole < budget) ? whole : budget;
			lost = whole - run;
			if (lost > LOST_SAT) begin
				lost = LOST_SAT;
			end
			total_steps += run;
			r.run = run[BUDGET_W-1:0];
			r.lost = lost[LOST_W-1:0];
			r.frac = FRAC_W'(({32'd0, carry_ns} << 16) / step);
			r.total = total_steps;
		end
		due_reports.push_back(r);
	endfunction

	function automatic int unsigned pick_gap(input bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 4);
		end
		if (r < 95) begin
			return $urandom_range(20, 90);
		end
		return $urandom_range(90, 300);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				account_tick(cmd_ch.cmd, cmd_ch.elapsed);
				ticks_taken++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					next_tick = tick_q.pop_front();
					cmd_ch.cmd <= next_tick.cmd;
					cmd_ch.elapsed <= next_tick.elapsed;
					cmd_ch.valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got_report.run = res_ch.run_steps;
				got_report.lost = res_ch.lost_steps;
				got_report.frac = res_ch.blend_fraction;
				got_report.total = res_ch.steps_total;
				if (due_reports.size() == 0) begin
					report_mismatch("unexpected result word", 64'(got_report.run), 64'd0);
				end else begin
					want_report = due_reports.pop_front();
					if (got_report.run !== want_report.run) begin
						report_mismatch("run_steps", 64'(got_report.run), 64'(want_report.run));
					end
					if (got_report.lost !== want_report.lost) begin
						report_mismatch("lost_steps", 64'(got_report.lost),
							64'(want_report.lost));
					end
					if (got_report.frac !== want_report.frac) begin
						report_mismatch("blend_fraction", 64'(got_report.frac),
							64'(want_report.frac));
					end
					if (got_report.total !== want_report.total) begin
						report_mismatch("steps_total", got_report.total, want_report.total);
					end
				end
			end
			if (recv_hold != 0) begin
				recv_hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!recv_calm && $urandom_range(0, 9) == 0) begin
					recv_hold = pick_gap(1'b0);
				end
			end
		end
	end

	task automatic queue_tick(input logic op, input logic signed [ELAPSED_W-1:0] el);
		tick_t t;
		t.cmd = op;
		t.elapsed = el;
		tick_q.push_back(t);
		ticks_queued++;
	endtask

	task automatic wait_idle();
		while (ticks_taken != ticks_queued || due_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_STEP_LENGTH) begin
			cfg_step_len = val;
		end else begin
			cfg_budget = val[BUDGET_W-1:0];
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_STEP_LENGTH && got !== cfg_step_len) begin
			report_mismatch("step_length read", 64'(got), 64'(cfg_step_len));
		end
		if (idx == REG_STEP_BUDGET && got[BUDGET_W-1:0] !== cfg_budget) begin
			report_mismatch("step_budget read", 64'(got[BUDGET_W-1:0]), 64'(cfg_budget));
		end
	endtask

	// Mostly elapsed times of up to 2 * budget + 2 whole steps plus a random part, so that the
	// budget and the carried remainder both come into play.
	function automatic logic signed [ELAPSED_W-1:0] make_elapsed();
		logic [63:0] step;
		logic [63:0] budget;
		logic [63:0] v;
		step = (cfg_step_len == '0) ? 64'd1 : {32'd0, cfg_step_len};
		budget = (cfg_budget == '0) ? 64'd1 : {48'd0, cfg_budget};
		case ($urandom_range(0, 9))
			0: begin
				v = {$urandom, $urandom};
			end
			1: begin
				v = -64'($urandom_range(0, 1000));
			end
			2: begin
				v = 64'($urandom_range(0, 3));
			end
			default: begin
				v = step * 64'($urandom_range(0, 32'(2 * budget + 2)))
					+ 64'($urandom) % step;
				if (v[63:ELAPSED_W-1] != '0) begin
					v = {17'd0, v[ELAPSED_W-2:0]};
				end
			end
		endcase
		return v[ELAPSED_W-1:0];
	endfunction

	task automatic fill_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 24) == 0) begin
				queue_tick(CMD_CLEAR, make_elapsed());
			end else begin
				queue_tick(CMD_ADVANCE, make_elapsed());
			end
		end
	endtask

	initial begin
		logic [DATA_W-1:0] len;
		logic [DATA_W-1:0] bud;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_tick(CMD_ADVANCE, '0);
		queue_tick(CMD_ADVANCE, ELAPSED_MIN);
		queue_tick(CMD_ADVANCE, -48'sd1);
		queue_tick(CMD_ADVANCE, 48'sd1);
		queue_tick(CMD_ADVANCE, 48'sd16666665);
		queue_tick(CMD_ADVANCE, 48'sd83333330);
		queue_tick(CMD_ADVANCE, 48'sd100000003);
		queue_tick(CMD_ADVANCE, ELAPSED_MAX);
		queue_tick(CMD_CLEAR, ELAPSED_MAX);
		queue_tick(CMD_ADVANCE, 48'sd100);
		wait_idle();

		write_reg(REG_STEP_LENGTH, '0);
		write_reg(REG_STEP_BUDGET, '0);
		queue_tick(CMD_ADVANCE, ELAPSED_MAX);
		queue_tick(CMD_ADVANCE, 48'sd1);
		queue_tick(CMD_CLEAR, '0);
		queue_tick(CMD_ADVANCE, 48'sd3);
		wait_idle();

		write_reg(REG_STEP_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_STEP_BUDGET, 32'h0000_FFFF);
		queue_tick(CMD_ADVANCE, ELAPSED_MAX);
		queue_tick(CMD_ADVANCE, 48'sh0000_FFFF_FFFE);
		queue_tick(CMD_ADVANCE, -48'sd5);
		queue_tick(CMD_ADVANCE, 48'sh0000_FFFF_FFFF);

		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			case ($urandom_range(0, 5))
				0: len = 32'd16666666;
				1: len = $urandom_range(1, 64);
				2: len = $urandom;
				3: len = 32'hFFFF_FFFF;
				4: len = '0;
				default: len = $urandom_range(1000, 100000);
			endcase
			case ($urandom_range(0, 4))
				0: bud = '0;
				1: bud = 32'd1;
				2: bud = 32'h0000_FFFF;
				3: bud = $urandom_range(2, 10);
				default: bud = $urandom_range(0, 65535);
			endcase
			write_reg(REG_STEP_LENGTH, len);
			write_reg(REG_STEP_BUDGET, bud);
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			fill_random(125);
			wait_idle();
			fill_random(125);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
